>>> rtl/pri_pkg.sv
// shared types, codes and constants of the pagerank power-iteration block
package pri_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int DEF_MAX_EDGES = 8192;
    localparam int NODE_W        = 10;
    localparam int CNT_W         = 11;
    localparam int RANK_W        = 32;
    localparam int DAMP_W        = 16;
    localparam int ITER_W        = 8;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DIV_W         = RANK_W + 1;

    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER  = 2'd2;

    localparam logic [CNT_W-1:0]  RST_NODES = 11'd1024;
    localparam logic [DAMP_W-1:0] RST_DAMP  = 16'd55706;
    localparam logic [ITER_W-1:0] RST_ITER  = 8'd100;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_WR,
        S_READ_WR,
        S_DIV_START,
        S_DIV_BASE,
        S_INIT_RANK,
        S_INIT_NEXT,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_EDGE_DIV,
        S_EDGE_WAIT,
        S_EDGE_MUL,
        S_EDGE_WR,
        S_COPY_RD,
        S_COPY_WR
    } eng_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   node;
        logic [RANK_W-1:0]   rank;
    } result_t;

endpackage

>>> rtl/pri_divider.sv
// serial restoring divider, one quotient bit per cycle
module pri_divider #(
    parameter int DEN_W = 14
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pri_pkg::DIV_W-1:0] num,
    input  logic [DEN_W-1:0]         den,
    output logic                     busy,
    output logic                     done,
    output logic [pri_pkg::DIV_W-1:0] quo
);

    localparam int CNT_BITS = $clog2(pri_pkg::DIV_W + 1);

    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [pri_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DEN_W:0]            trial;
    logic [DEN_W:0]            diff;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    // one shift and trial subtract per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[pri_pkg::DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
            cnt_next  = CNT_BITS'(pri_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[pri_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[pri_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(start))
        else $error("divider done held for two cycles");

endmodule

>>> rtl/pri_engine.sv
// edge, degree and rank memories with the sequencer that runs the iterations
module pri_engine #(
    parameter int MAX_EDGES = pri_pkg::DEF_MAX_EDGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pri_pkg::MODE_W-1:0]    mode,
    input  logic [pri_pkg::NODE_W-1:0]    src_node,
    input  logic [pri_pkg::NODE_W-1:0]    dst_node,
    input  logic [pri_pkg::CNT_W-1:0]     node_count,
    input  logic [pri_pkg::DAMP_W-1:0]    damping,
    input  logic [pri_pkg::ITER_W-1:0]    iteration_count,
    output logic                          ready,
    output logic                          res_valid,
    output pri_pkg::result_t              res
);

    localparam int DEG_W  = $clog2(MAX_EDGES + 1);
    localparam int EA_W   = $clog2(MAX_EDGES);
    localparam int EDGE_W = 2 * pri_pkg::NODE_W;
    localparam int DEN_W  = (DEG_W > pri_pkg::CNT_W) ? DEG_W : pri_pkg::CNT_W;
    localparam int NW     = pri_pkg::NODE_W;
    localparam int RW     = pri_pkg::RANK_W;
    localparam int PROD_W = pri_pkg::DAMP_W + RW;

    // memories
    logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [DEG_W-1:0]  deg_mem  [pri_pkg::MAX_NODES];
    logic [RW-1:0]     rank_mem [pri_pkg::MAX_NODES];
    logic [RW-1:0]     next_mem [pri_pkg::MAX_NODES];

    logic [EDGE_W-1:0] edge_rd_reg;
    logic [DEG_W-1:0]  deg_rd_reg;
    logic [RW-1:0]     rank_rd_reg;
    logic [RW-1:0]     next_rd_reg;

    logic              edge_we;
    logic [EA_W-1:0]   edge_waddr, edge_raddr;
    logic [EDGE_W-1:0] edge_wdata;
    logic              deg_we;
    logic [NW-1:0]     deg_waddr, deg_raddr;
    logic [DEG_W-1:0]  deg_wdata;
    logic              rank_we;
    logic [NW-1:0]     rank_waddr, rank_raddr;
    logic [RW-1:0]     rank_wdata;
    logic              next_we;
    logic [NW-1:0]     next_waddr, next_raddr;
    logic [RW-1:0]     next_wdata;

    // control and datapath state
    pri_pkg::eng_state_t           state_reg, state_next;
    logic [DEG_W-1:0]              edges_held_reg, edges_held_next;
    logic [DEG_W-1:0]              e_reg, e_next;
    logic [pri_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic [pri_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic                          valid_reg, valid_next;
    logic                          res_valid_reg, res_valid_next;
    pri_pkg::result_t              res_reg, res_next;
    logic [NW-1:0]                 a_reg, a_next;
    logic [RW-1:0]                 start_val_reg, start_val_next;
    logic [RW-1:0]                 base_reg, base_next;
    logic [RW-1:0]                 share_reg, share_next;
    logic [RW-1:0]                 term_reg, term_next;

    logic [pri_pkg::CNT_W-1:0]     n_use;
    logic [NW-1:0]                 e_src, e_dst;
    logic [PROD_W-1:0]             prod;
    logic [RW:0]                   sum;
    logic [pri_pkg::DIV_W-1:0]     sat_src;
    logic [RW:0]                   damp_comp;

    logic                          div_start, div_busy, div_done;
    logic [pri_pkg::DIV_W-1:0]     div_num, div_quo;
    logic [DEN_W-1:0]              div_den;

    pri_divider #(.DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // memory ports, registered read data
    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        edge_rd_reg <= edge_mem[edge_raddr];
        if (deg_we)
            deg_mem[deg_waddr] <= deg_wdata;
        deg_rd_reg <= deg_mem[deg_raddr];
        if (rank_we)
            rank_mem[rank_waddr] <= rank_wdata;
        rank_rd_reg <= rank_mem[rank_raddr];
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        next_rd_reg <= next_mem[next_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pri_pkg::S_CLEAR;
            edges_held_reg <= '0;
            e_reg          <= '0;
            idx_reg        <= '0;
            iter_reg       <= '0;
            valid_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edges_held_reg <= edges_held_next;
            e_reg          <= e_next;
            idx_reg        <= idx_next;
            iter_reg       <= iter_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        a_reg         <= a_next;
        start_val_reg <= start_val_next;
        base_reg      <= base_next;
        share_reg     <= share_next;
        term_reg      <= term_next;
    end

    // node count clamped to one through the node capacity
    always_comb
    begin
        if (node_count == '0)
            n_use = pri_pkg::CNT_W'(1);
        else if (node_count > pri_pkg::CNT_W'(pri_pkg::MAX_NODES))
            n_use = pri_pkg::CNT_W'(pri_pkg::MAX_NODES);
        else
            n_use = node_count;
    end

    assign e_src     = edge_rd_reg[EDGE_W-1:NW];
    assign e_dst     = edge_rd_reg[NW-1:0];
    assign prod      = damping * share_reg;
    assign sum       = {1'b0, next_rd_reg} + {1'b0, term_reg};
    assign sat_src   = div_quo;
    assign damp_comp = (RW + 1)'(17'h10000 - {1'b0, damping});

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        edges_held_next = edges_held_reg;
        e_next          = e_reg;
        idx_next        = idx_reg;
        iter_next       = iter_reg;
        valid_next      = valid_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        a_next          = a_reg;
        start_val_next  = start_val_reg;
        base_next       = base_reg;
        share_next      = share_reg;
        term_next       = term_reg;

        edge_we    = 1'b0;
        edge_waddr = edges_held_reg[EA_W-1:0];
        edge_wdata = {src_node, dst_node};
        edge_raddr = e_reg[EA_W-1:0];
        deg_we     = 1'b0;
        deg_waddr  = a_reg;
        deg_wdata  = deg_rd_reg + 1'b1;
        deg_raddr  = src_node;
        rank_we    = 1'b0;
        rank_waddr = idx_reg[NW-1:0];
        rank_wdata = start_val_reg;
        rank_raddr = src_node;
        next_we    = 1'b0;
        next_waddr = idx_reg[NW-1:0];
        next_wdata = base_reg;
        next_raddr = idx_reg[NW-1:0];

        div_start = 1'b0;
        div_num   = {1'b1, {RW{1'b0}}};
        div_den   = DEN_W'(n_use);

        case (state_reg)
            pri_pkg::S_CLEAR:
            begin
                deg_we    = 1'b1;
                deg_waddr = idx_reg[NW-1:0];
                deg_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == pri_pkg::CNT_W'(pri_pkg::MAX_NODES - 1))
                begin
                    idx_next   = '0;
                    state_next = pri_pkg::S_IDLE;
                end
            end

            pri_pkg::S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    a_next   = src_node;
                    case (mode)
                        pri_pkg::MODE_ADD:
                        begin
                            if ({1'b0, src_node} >= n_use || {1'b0, dst_node} >= n_use)
                            begin
                                res_next.status = pri_pkg::ST_RANGE;
                                res_valid_next  = 1'b1;
                            end
                            else if (edges_held_reg == DEG_W'(MAX_EDGES))
                            begin
                                res_next.status = pri_pkg::ST_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                edge_we         = 1'b1;
                                edges_held_next = edges_held_reg + 1'b1;
                                state_next      = pri_pkg::S_ADD_WR;
                            end
                        end
                        pri_pkg::MODE_RUN:
                        begin
                            div_start  = 1'b1;
                            state_next = pri_pkg::S_DIV_START;
                        end
                        pri_pkg::MODE_READ:
                        begin
                            if ({1'b0, src_node} >= n_use)
                            begin
                                res_next.status = pri_pkg::ST_RANGE;
                                res_valid_next  = 1'b1;
                            end
                            else if (!valid_reg)
                            begin
                                res_next.status = pri_pkg::ST_NOT_READY;
                                res_valid_next  = 1'b1;
                            end
                            else
                                state_next = pri_pkg::S_READ_WR;
                        end
                        default:
                            res_valid_next = 1'b1;
                    endcase
                end
            end

            // degree read back, bump it
            pri_pkg::S_ADD_WR:
            begin
                deg_we         = 1'b1;
                res_valid_next = 1'b1;
                state_next     = pri_pkg::S_IDLE;
            end

            pri_pkg::S_READ_WR:
            begin
                res_next.node  = a_reg;
                res_next.rank  = rank_rd_reg;
                res_valid_next = 1'b1;
                state_next     = pri_pkg::S_IDLE;
            end

            // starting rank 1/n, then base (1-d)/n
            pri_pkg::S_DIV_START:
            begin
                if (div_done)
                begin
                    start_val_next = sat_src[RW] ? {RW{1'b1}} : sat_src[RW-1:0];
                    div_start      = 1'b1;
                    div_num        = {damp_comp[pri_pkg::DAMP_W:0],
                                      {(RW - pri_pkg::DAMP_W){1'b0}}};
                    state_next     = pri_pkg::S_DIV_BASE;
                end
            end

            pri_pkg::S_DIV_BASE:
            begin
                if (div_done)
                begin
                    base_next  = sat_src[RW] ? {RW{1'b1}} : sat_src[RW-1:0];
                    idx_next   = '0;
                    iter_next  = iteration_count;
                    state_next = pri_pkg::S_INIT_RANK;
                end
            end

            pri_pkg::S_INIT_RANK:
            begin
                rank_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_use - 1'b1)
                begin
                    idx_next = '0;
                    if (iter_reg == '0)
                    begin
                        valid_next     = 1'b1;
                        res_valid_next = 1'b1;
                        state_next     = pri_pkg::S_IDLE;
                    end
                    else
                        state_next = pri_pkg::S_INIT_NEXT;
                end
            end

            pri_pkg::S_INIT_NEXT:
            begin
                next_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_use - 1'b1)
                begin
                    idx_next   = '0;
                    e_next     = '0;
                    state_next = pri_pkg::S_EDGE_RD;
                end
            end

            // edge pass
            pri_pkg::S_EDGE_RD:
            begin
                if (e_reg == edges_held_reg)
                begin
                    idx_next   = '0;
                    state_next = pri_pkg::S_COPY_RD;
                end
                else
                    state_next = pri_pkg::S_EDGE_CHK;
            end

            pri_pkg::S_EDGE_CHK:
            begin
                deg_raddr  = e_src;
                rank_raddr = e_src;
                a_next     = e_dst;
                if ({1'b0, e_src} >= n_use || {1'b0, e_dst} >= n_use)
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = pri_pkg::S_EDGE_RD;
                end
                else
                    state_next = pri_pkg::S_EDGE_DIV;
            end

            pri_pkg::S_EDGE_DIV:
            begin
                div_num = {1'b0, rank_rd_reg};
                div_den = DEN_W'(deg_rd_reg);
                if (deg_rd_reg == '0)
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = pri_pkg::S_EDGE_RD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = pri_pkg::S_EDGE_WAIT;
                end
            end

            pri_pkg::S_EDGE_WAIT:
            begin
                next_raddr = a_reg;
                if (div_done)
                begin
                    share_next = div_quo[RW-1:0];
                    state_next = pri_pkg::S_EDGE_MUL;
                end
            end

            pri_pkg::S_EDGE_MUL:
            begin
                next_raddr = a_reg;
                term_next  = prod[PROD_W-1:pri_pkg::DAMP_W];
                state_next = pri_pkg::S_EDGE_WR;
            end

            // accumulate with saturation
            pri_pkg::S_EDGE_WR:
            begin
                next_raddr = a_reg;
                next_we    = 1'b1;
                next_waddr = a_reg;
                next_wdata = sum[RW] ? {RW{1'b1}} : sum[RW-1:0];
                e_next     = e_reg + 1'b1;
                state_next = pri_pkg::S_EDGE_RD;
            end

            // copy new ranks over the old
            pri_pkg::S_COPY_RD:
                state_next = pri_pkg::S_COPY_WR;

            pri_pkg::S_COPY_WR:
            begin
                rank_we    = 1'b1;
                rank_wdata = next_rd_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = pri_pkg::S_COPY_RD;
                if (idx_reg == n_use - 1'b1)
                begin
                    idx_next  = '0;
                    iter_next = iter_reg - 1'b1;
                    if (iter_reg == pri_pkg::ITER_W'(1))
                    begin
                        valid_next     = 1'b1;
                        res_valid_next = 1'b1;
                        state_next     = pri_pkg::S_IDLE;
                    end
                    else
                        state_next = pri_pkg::S_INIT_NEXT;
                end
            end

            default:
                state_next = pri_pkg::S_IDLE;
        endcase
    end

    assign ready     = (state_reg == pri_pkg::S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_held_reg <= DEG_W'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == pri_pkg::S_IDLE && !res_valid_reg)
        else $error("item taken while engine busy");

    a_edge_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pri_pkg::S_EDGE_CHK |-> e_reg < edges_held_reg)
        else $error("edge read past stored edges");

    a_div_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pri_pkg::S_IDLE |-> !div_busy)
        else $error("divider still running while engine idle");

endmodule

>>> rtl/pagerank_power_iteration.sv
// top level: stream ports, configuration registers and result register
// Usage: edges, compute requests and rank reads enter on the s_ group, one
// beat per item; s_tuser carries the mode (0 add edge, 1 run, 2 read rank).
// Each item gives exactly one result beat on the m_ group, with the status
// on m_tuser. Configuration (node count, damping, iterations) is to be written
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this. An edge load passes S_ADD_WR and a rank read
// passes S_READ_WR; a rejected item or an unused mode is answered from S_IDLE.
// Every result then passes the result register. A compute item runs the two
// serial divisions of 1/n and (1-d)/n, seeds the n ranks, then per iteration
// seeds new ranks, divides rank by out-degree serially for each stored edge
// in range and copies the ranks back. One item is in work at a time; s_tready
// is low while an item runs or a result beat is waiting. When m_tready is low
// the result holds and no new item is taken. After reset the out-degree
// memory is swept clear over all 1024 entries before the first item is taken;
// configuration writes work then.
module pagerank_power_iteration #(
    parameter int MAX_EDGES = pri_pkg::DEF_MAX_EDGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // src_node, dst_node, zero fill
    input  logic [pri_pkg::MODE_W-1:0]       s_tuser,   // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,   // node, rank, zero fill
    output logic [pri_pkg::STATUS_W-1:0]     m_tuser,   // status
    input  logic                             cfg_we,
    input  logic [pri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pri_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [pri_pkg::CNT_W-1:0]  node_count_reg;
    logic [pri_pkg::DAMP_W-1:0] damping_reg;
    logic [pri_pkg::ITER_W-1:0] iter_reg;
    logic                       out_valid_reg;
    pri_pkg::result_t           out_reg;
    logic                       eng_ready, eng_res_valid, in_beat;
    pri_pkg::result_t           eng_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= pri_pkg::RST_NODES;
            damping_reg    <= pri_pkg::RST_DAMP;
            iter_reg       <= pri_pkg::RST_ITER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pri_pkg::CFG_NODES: node_count_reg <= cfg_data[pri_pkg::CNT_W-1:0];
                pri_pkg::CFG_DAMP:  damping_reg    <= cfg_data;
                pri_pkg::CFG_ITER:  iter_reg       <= cfg_data[pri_pkg::ITER_W-1:0];
                default:            ;
            endcase
        end
    end

    assign s_tready = eng_ready && !out_valid_reg;
    assign in_beat  = s_tvalid && s_tready;

    pri_engine #(.MAX_EDGES(MAX_EDGES)) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (in_beat),
        .mode            (s_tuser),
        .src_node        (s_tdata[9:0]),
        .dst_node        (s_tdata[19:10]),
        .node_count      (node_count_reg),
        .damping         (damping_reg),
        .iteration_count (iter_reg),
        .ready           (eng_ready),
        .res_valid       (eng_res_valid),
        .res             (eng_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eng_res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid)
            out_reg <= eng_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0, out_reg.rank, out_reg.node};

endmodule

>>> test/tb_pagerank_power_iteration.sv
// testbench for the pagerank power-iteration block: directed and random items with a rank predictor
module tb_pagerank_power_iteration;

    localparam int EDGE_CAP     = pri_pkg::DEF_MAX_EDGES;
    localparam int EDGE_BUDGET  = 160;
    localparam longint unsigned RANK_ALL = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int NW           = pri_pkg::NODE_W;
    localparam logic [pri_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata   = '0;
    logic [pri_pkg::MODE_W-1:0]    s_tuser   = pri_pkg::MODE_ADD;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [47:0]                   m_tdata;
    logic [pri_pkg::STATUS_W-1:0]  m_tuser;
    logic                          cfg_we    = 1'b0;
    logic [pri_pkg::CFG_IDX_W-1:0] cfg_index = pri_pkg::CFG_NODES;
    logic [pri_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pagerank_power_iteration dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [pri_pkg::CNT_W-1:0]  nodes_reg = pri_pkg::RST_NODES;
    logic [pri_pkg::DAMP_W-1:0] damp_reg  = pri_pkg::RST_DAMP;
    logic [pri_pkg::ITER_W-1:0] iter_reg  = pri_pkg::RST_ITER;
    logic [NW-1:0]     edge_src_mem [EDGE_CAP];
    logic [NW-1:0]     edge_dst_mem [EDGE_CAP];
    int unsigned       edges_held = 0;
    int unsigned       src_degree [pri_pkg::MAX_NODES];
    longint unsigned   rank_mem [pri_pkg::MAX_NODES];
    longint unsigned   next_rank_mem [pri_pkg::MAX_NODES];
    bit                rank_written [pri_pkg::MAX_NODES];
    bit                ranks_ready = 1'b0;

    pri_pkg::result_t expected_results[$];
    int          fail_count = 0;
    int          beats_checked = 0;
    int          computes_sent = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;
    int          ready_hold = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run guard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [NW-1:0] nd(int unsigned v);
        return NW'(v);
    endfunction

    function automatic int unsigned active_nodes();
        if (nodes_reg == 0)
            return 1;
        if (nodes_reg > pri_pkg::MAX_NODES)
            return pri_pkg::MAX_NODES;
        return nodes_reg;
    endfunction

    function automatic longint unsigned clip_rank(longint unsigned v);
        return (v > RANK_ALL) ? RANK_ALL : v;
    endfunction

    // power iterations over the stored graph
    function automatic void run_power_iterations();
        int unsigned     n;
        int unsigned     s;
        int unsigned     t;
        longint unsigned dv;
        longint unsigned seed_rank;
        longint unsigned base_rank;
        longint unsigned share;
        longint unsigned term;
        n = active_nodes();
        dv = damp_reg;
        seed_rank = clip_rank((64'd1 << 32) / n);
        base_rank = clip_rank(((64'd65536 - dv) << 16) / n);
        for (int i = 0; i < n; i++)
        begin
            rank_mem[i] = seed_rank;
            rank_written[i] = 1'b1;
        end
        for (int it = 0; it < iter_reg; it++)
        begin
            for (int i = 0; i < n; i++)
                next_rank_mem[i] = base_rank;
            for (int e = 0; e < edges_held; e++)
            begin
                s = edge_src_mem[e];
                t = edge_dst_mem[e];
                if (s >= n || t >= n || src_degree[s] == 0)
                    continue;
                share = rank_mem[s] / src_degree[s];
                term = (dv * share) >> 16;
                next_rank_mem[t] = clip_rank(next_rank_mem[t] + term);
            end
            for (int i = 0; i < n; i++)
                rank_mem[i] = next_rank_mem[i];
        end
        ranks_ready = 1'b1;
    endfunction

    // expected result of one accepted item, updating the predictor state
    function automatic pri_pkg::result_t predict_result(logic [pri_pkg::MODE_W-1:0] mode,
                                                        logic [NW-1:0] src,
                                                        logic [NW-1:0] dst);
        pri_pkg::result_t r;
        int unsigned      n;
        r = '0;
        n = active_nodes();
        case (mode)
            pri_pkg::MODE_ADD:
            begin
                if (src >= n || dst >= n)
                    r.status = pri_pkg::ST_RANGE;
                else if (edges_held >= EDGE_CAP)
                    r.status = pri_pkg::ST_FULL;
                else
                begin
                    edge_src_mem[edges_held] = src;
                    edge_dst_mem[edges_held] = dst;
                    edges_held++;
                    src_degree[src]++;
                end
            end
            pri_pkg::MODE_RUN:
                run_power_iterations();
            pri_pkg::MODE_READ:
            begin
                if (src >= n)
                    r.status = pri_pkg::ST_RANGE;
                else if (!ranks_ready)
                    r.status = pri_pkg::ST_NOT_READY;
                else
                begin
                    r.node = src;
                    r.rank = rank_mem[src][pri_pkg::RANK_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result side: random stalls and field checks
    always @(posedge clk) begin
        pri_pkg::result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[9:0] !== want.node)
                    begin
                        $error("node: expected %0d, got %0d", want.node, m_tdata[9:0]);
                        fail_count++;
                    end
                    if (m_tdata[41:10] !== want.rank)
                    begin
                        $error("rank: expected %0h, got %0h", want.rank, m_tdata[41:10]);
                        fail_count++;
                    end
                end
                ready_hold = no_idle ? 0 : $urandom_range(0, 14);
                m_tready <= (ready_hold == 0);
            end
            else if (ready_hold > 0)
            begin
                ready_hold--;
                m_tready <= (ready_hold == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one input beat, expectation recorded at acceptance
    task automatic send_item(logic [pri_pkg::MODE_W-1:0] mode, logic [NW-1:0] src,
                             logic [NW-1:0] dst);
        int               gap;
        pri_pkg::result_t exp_res;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, dst, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_res = predict_result(mode, src, dst);
        expected_results = {expected_results, exp_res};
        if (mode == pri_pkg::MODE_RUN)
            computes_sent++;
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [pri_pkg::CFG_IDX_W-1:0] idx,
                             logic [pri_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pri_pkg::CFG_NODES: nodes_reg = val[pri_pkg::CNT_W-1:0];
            pri_pkg::CFG_DAMP:  damp_reg  = val;
            pri_pkg::CFG_ITER:  iter_reg  = val[pri_pkg::ITER_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic setup(int nodes, int damp, int iters);
        drain();
        write_reg(pri_pkg::CFG_NODES, pri_pkg::CFG_DATA_W'(nodes));
        write_reg(pri_pkg::CFG_DAMP, pri_pkg::CFG_DATA_W'(damp));
        write_reg(pri_pkg::CFG_ITER, pri_pkg::CFG_DATA_W'(iters));
    endtask

    // reads before any compute, full-size index, unused mode
    task automatic test_not_ready();
        send_item(pri_pkg::MODE_READ, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd1023, 10'd1023);
        send_item(MODE_UNUSED, 10'd1023, 10'd1023);
        send_item(MODE_UNUSED, 10'd0, 10'd0);
    endtask

    // small graph with a dangling node and rejected edges
    task automatic test_small_graph();
        setup(4, 55706, 2);
        send_item(pri_pkg::MODE_ADD, 10'd0, 10'd1);
        send_item(pri_pkg::MODE_ADD, 10'd1, 10'd2);
        send_item(pri_pkg::MODE_ADD, 10'd2, 10'd0);
        send_item(pri_pkg::MODE_ADD, 10'd0, 10'd2);
        send_item(pri_pkg::MODE_ADD, 10'd2, 10'd3);
        send_item(pri_pkg::MODE_ADD, 10'd4, 10'd0);
        send_item(pri_pkg::MODE_ADD, 10'd0, 10'd1023);
        send_item(pri_pkg::MODE_READ, 10'd2, 10'd0);
        send_item(pri_pkg::MODE_RUN, 10'd0, 10'd0);
        for (int i = 0; i < 5; i++)
            send_item(pri_pkg::MODE_READ, nd(i), 10'd0);
    endtask

    // zero and maximum iterations, damping extremes, node count clamping
    task automatic test_register_extremes();
        setup(4, 0, 0);
        send_item(pri_pkg::MODE_RUN, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd3, 10'd0);
        setup(2, 65535, 255);
        send_item(pri_pkg::MODE_RUN, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd1, 10'd0);
        // node count zero acts as one node
        setup(0, 0, 1);
        send_item(pri_pkg::MODE_RUN, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd1, 10'd0);
        // oversized node count clamps to the maximum
        setup(2047, 30000, 1);
        send_item(pri_pkg::MODE_RUN, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd1023, 10'd0);
        send_item(pri_pkg::MODE_ADD, 10'd1023, 10'd1022);
    endtask

    // lowered node count leaves out-of-range edges in the store
    task automatic test_stale_edges();
        setup(2, 55706, 3);
        send_item(pri_pkg::MODE_RUN, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd0, 10'd0);
        send_item(pri_pkg::MODE_READ, 10'd1, 10'd0);
        setup(4, 40000, 1);
        send_item(pri_pkg::MODE_ADD, 10'd3, 10'd1);
        send_item(pri_pkg::MODE_READ, 10'd3, 10'd0);
    endtask

    function automatic logic [NW-1:0] pick_read_node(int unsigned n);
        logic [NW-1:0] v;
        for (int k = 0; k < 8; k++)
        begin
            v = nd($urandom_range(0, n - 1));
            if (!ranks_ready || rank_written[v])
                return v;
        end
        return '0;
    endfunction

    // random traffic in segments, each with its own register setting
    task automatic test_random_traffic(int segments, int per_segment);
        int unsigned   n;
        int            sel;
        int            nodes_val;
        int            iters_val;
        int            damp_val;
        logic [NW-1:0] a;
        logic [NW-1:0] b;
        for (int seg = 0; seg < segments; seg++)
        begin
            sel = $urandom_range(0, 19);
            nodes_val = (sel == 0) ? 0 : (sel == 1) ? 1024 : (sel == 2) ? 2047
                      : $urandom_range(1, 32);
            iters_val = (sel < 3) ? 1 : $urandom_range(0, 4);
            sel = $urandom_range(0, 9);
            damp_val = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 65535);
            setup(nodes_val, damp_val, iters_val);
            no_idle = (seg % 4 == 3);
            n = active_nodes();
            for (int i = 0; i < per_segment; i++)
            begin
                if (i == per_segment / 2 && seg % 3 == 0)
                    drain();
                sel = $urandom_range(0, 99);
                if (sel < 30 && edges_held < EDGE_BUDGET)
                    send_item(pri_pkg::MODE_ADD, nd($urandom_range(0, n - 1)),
                              nd($urandom_range(0, n - 1)));
                else if (sel < 40 && n < pri_pkg::MAX_NODES)
                begin
                    a = nd($urandom_range(0, 1023));
                    b = nd($urandom_range(n, 1023));
                    if ($urandom_range(0, 1))
                        send_item(pri_pkg::MODE_ADD, a, b);
                    else
                        send_item(pri_pkg::MODE_ADD, b, a);
                end
                else if (sel == 40)
                    send_item(pri_pkg::MODE_RUN, nd($urandom_range(0, 1023)),
                              nd($urandom_range(0, 1023)));
                else if (sel < 43)
                    send_item(MODE_UNUSED, nd($urandom_range(0, 1023)),
                              nd($urandom_range(0, 1023)));
                else if (sel < 50 && n < pri_pkg::MAX_NODES)
                    send_item(pri_pkg::MODE_READ, nd($urandom_range(n, 1023)),
                              nd($urandom_range(0, 1023)));
                else
                    send_item(pri_pkg::MODE_READ, pick_read_node(n),
                              nd($urandom_range(0, 1023)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_not_ready();
        test_small_graph();
        test_register_extremes();
        test_stale_edges();
        test_random_traffic(12, 152);
        drain();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("checked %0d result beats, %0d compute runs, %0d edges stored",
                 beats_checked, computes_sent, edges_held);
        $display("covered register extremes, stale edges, rejected items and random stalls");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/pri_pkg.sv
rtl/pri_divider.sv
rtl/pri_engine.sv
rtl/pagerank_power_iteration.sv
test/tb_pagerank_power_iteration.sv
